### src/erfpa_pkg.sv
// Shared constants, coefficient table and divider interface types of the erf block.
`default_nettype none

package erfpa_pkg;

   // Fixed-point formats.
   localparam int FRAC_BITS = 28;
   localparam int ARG_W     = 32;
   localparam int RES_W     = 32;

   // Horner evaluation: multiplier operand width and polynomial width.
   localparam int ACC_W  = 30;
   localparam int POLY_W = 33;
   localparam int PROD_W = ACC_W + ARG_W;
   localparam int HSTEPS = 6;

   // Squaring chain: operands are capped at 2^44 and split into 13 + 32 bits.
   localparam int NUM_SQ   = 4;
   localparam int SQ_W     = 45;
   localparam int SQ_LO_W  = 32;
   localparam int SQ_HI_W  = SQ_W - SQ_LO_W;
   localparam int HH_W     = 25;
   localparam int MID_W    = 44;
   localparam int SUM_W    = 89;
   localparam int SQR_W    = SUM_W - FRAC_BITS;

   // Reciprocal stage.
   localparam int DEN_W = 60;
   localparam int QUO_W = 31;

   localparam logic [FRAC_BITS-1:0] HALF_Q28 = {1'b1, 27'd0};
   localparam logic [ACC_W-1:0]     COEF_A6  = 30'd11560;
   localparam logic [SQ_W-1:0]      SQ_CAP   = {1'b1, 44'd0};
   localparam logic [QUO_W-1:0]     ONE_Q30  = {1'b1, 30'd0};
   localparam logic [DEN_W-1:0]     ONE_Q58  = {2'b01, 58'd0};

   // Coefficient added after each Horner multiply: a5, a4, a3, a2, a1, then 1.0 (Q0.28).
   function automatic logic [POLY_W-1:0] horner_add(input logic [2:0] step);
      logic [POLY_W-1:0] c;
      case (step)
         3'd0:    c = 33'd74240;
         3'd1:    c = 33'd40806;
         3'd2:    c = 33'd2488538;
         3'd3:    c = 33'd11349991;
         3'd4:    c = 33'd18930895;
         3'd5:    c = 33'd268435456;
         default: c = '0;
      endcase
      return c;
   endfunction

   // Request into the reciprocal divider.
   typedef struct packed {
      logic [DEN_W-1:0] num;
      logic [DEN_W-1:0] den;
      logic             neg;
      logic             sat;
   } div_req_type;

   // Result out of the reciprocal divider.
   typedef struct packed {
      logic [QUO_W-1:0] quo;
      logic             neg;
      logic             sat;
   } div_rsp_type;

endpackage

`default_nettype wire

### src/erf_polynomial_approx.sv
// Top level of the pipelined fixed-point error function (polynomial approximation).
//
// Usage:
//   Requests enter on the req_ stream: req_tdata carries the argument x as a
//   signed Q3.28 value. Results leave on the rsp_ stream: rsp_tdata carries
//   erf(x) as a signed Q1.30 value in the range -1.0 .. +1.0.
//   Each request gives exactly one result, in request order.
//   From acceptance to the output, a request passes through one input stage,
//   six Horner multiply stages, four squaring steps of three stages each, one
//   divider setup stage, 31 divider stages (one quotient bit per stage) and
//   the output register. The divider holds most of those stages.
//   Throughput is one request per clock cycle while rsp_tready stays high.
//   Reset clears only the valid bits; the data registers keep whatever they hold.
//   When the receiver holds rsp_tready low, the result waits in the output
//   register and the stages behind it keep filling their empty slots, so
//   req_tready drops only once every stage holds a request.
`default_nettype none

module erf_polynomial_approx
   import erfpa_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [ARG_W-1:0] req_tdata,   // [31:0] arg_value
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RES_W-1:0]      rsp_tdata    // [31:0] erf_value
);

   localparam int SQ_BASE = 1 + HSTEPS;
   localparam int PREP    = SQ_BASE + 3 * NUM_SQ;
   localparam int NSTG    = PREP + 1;

   // Stage handshake for everything ahead of the divider.
   logic [NSTG-1:0]   v_ff;
   logic [NSTG-1:0]   v_in;
   logic [NSTG-1:0]   v_src;
   logic [NSTG-1:0]   stg_en;

   // Input stage: magnitude and sign of the argument.
   logic [ARG_W-1:0]  in_t_ff;
   logic [ARG_W-1:0]  in_t_in;
   logic              in_neg_ff;

   // Horner stages.
   logic [POLY_W-1:0] h_acc_ff [HSTEPS];
   logic [ARG_W-1:0]  h_t_ff   [HSTEPS-1];
   logic              h_neg_ff [HSTEPS];

   // Squaring outputs.
   logic [SQR_W-1:0]  sq_r_ff   [NUM_SQ];
   logic              sq_neg_ff [NUM_SQ];

   // Divider setup and divider.
   div_req_type       prep_ff;
   div_req_type       prep_in;
   logic              div_in_ready;
   logic              div_out_valid;
   logic              div_out_ready;
   div_rsp_type       div_rsp;

   // Output register.
   logic              rsp_v_ff;
   logic [RES_W-1:0]  rsp_data_ff;
   logic [RES_W-1:0]  rsp_data_in;
   logic [QUO_W-1:0]  mag_in;
   logic              out_en;

   // ---------------------------------------------------------------------
   // Handshake. A stage loads when it is empty or when its request moves on,
   // so empty slots fill up even while the output is stalled.
   // ---------------------------------------------------------------------
   assign stg_en[NSTG-1] = !v_ff[NSTG-1] || div_in_ready;
   for (genvar i = 0; i < NSTG - 1; i++) begin : g_en
      assign stg_en[i] = !v_ff[i] || stg_en[i+1];
   end

   assign v_src      = {v_ff[NSTG-2:0], req_tvalid};
   assign v_in       = (stg_en & v_src) | (~stg_en & v_ff);
   assign req_tready = stg_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input stage. The most negative argument turns into magnitude 8.0,
   // which still fits the unsigned 32-bit magnitude.
   // ---------------------------------------------------------------------
   assign in_t_in = req_tdata[ARG_W-1] ? (~req_tdata + 32'd1) : req_tdata;

   always_ff @(posedge clock) begin
      if (stg_en[0]) begin
         in_t_ff   <= in_t_in;
         in_neg_ff <= req_tdata[ARG_W-1];
      end
   end

   // ---------------------------------------------------------------------
   // Horner's rule, one multiply per stage. The first step of the rule only
   // loads a6, so it is a constant here. Partial sums ahead of the last
   // multiply stay below 4.0, which keeps the multiplier at 30 x 32 bits.
   // ---------------------------------------------------------------------
   for (genvar k = 0; k < HSTEPS; k++) begin : g_horner
      logic [ACC_W-1:0]  acc_src;
      logic [ARG_W-1:0]  t_src;
      logic              neg_src;
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] prod_r;
      logic [POLY_W-1:0] acc_in;

      if (k == 0) begin : g_first
         assign acc_src = COEF_A6;
         assign t_src   = in_t_ff;
         assign neg_src = in_neg_ff;
      end else begin : g_next
         assign acc_src = h_acc_ff[k-1][ACC_W-1:0];
         assign t_src   = h_t_ff[k-1];
         assign neg_src = h_neg_ff[k-1];
      end

      assign prod   = acc_src * t_src;
      assign prod_r = prod + PROD_W'(HALF_Q28);
      assign acc_in = prod_r[FRAC_BITS+POLY_W-1:FRAC_BITS] + horner_add(3'(k));

      always_ff @(posedge clock) begin
         if (stg_en[1+k]) begin
            h_acc_ff[k] <= acc_in;
            h_neg_ff[k] <= neg_src;
         end
      end

      if (k < HSTEPS - 1) begin : g_keep_t
         always_ff @(posedge clock) begin
            if (stg_en[1+k]) begin
               h_t_ff[k] <= t_src;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Four rounded squares give p^16. Each square takes three stages: low
   // product and high product, then the cross product, then the sum and
   // rounding. An operand of 2^44 or more is capped at 2^44: its square is
   // already past 2^59, and from there the result is one no matter what.
   // ---------------------------------------------------------------------
   for (genvar k = 0; k < NUM_SQ; k++) begin : g_square
      logic [SQR_W-1:0]   s_src;
      logic               neg_src;
      logic [SQ_W-1:0]    a_in;
      logic [2*SQ_LO_W-1:0] ll0_ff;
      logic [HH_W-1:0]    hh0_ff;
      logic [SQ_HI_W-1:0] ah0_ff;
      logic [SQ_LO_W-1:0] al0_ff;
      logic               neg0_ff;
      logic [2*SQ_LO_W-1:0] ll1_ff;
      logic [HH_W-1:0]    hh1_ff;
      logic [MID_W-1:0]   mid1_ff;
      logic               neg1_ff;
      logic [SUM_W-1:0]   sum;

      if (k == 0) begin : g_first
         assign s_src   = SQR_W'(h_acc_ff[HSTEPS-1]);
         assign neg_src = h_neg_ff[HSTEPS-1];
      end else begin : g_next
         assign s_src   = sq_r_ff[k-1];
         assign neg_src = sq_neg_ff[k-1];
      end

      assign a_in = (|s_src[SQR_W-1:SQ_W-1]) ? SQ_CAP : s_src[SQ_W-1:0];

      always_ff @(posedge clock) begin
         if (stg_en[SQ_BASE+3*k]) begin
            ll0_ff  <= a_in[SQ_LO_W-1:0] * a_in[SQ_LO_W-1:0];
            hh0_ff  <= HH_W'(a_in[SQ_W-1:SQ_LO_W] * a_in[SQ_W-1:SQ_LO_W]);
            ah0_ff  <= a_in[SQ_W-1:SQ_LO_W];
            al0_ff  <= a_in[SQ_LO_W-1:0];
            neg0_ff <= neg_src;
         end
      end

      always_ff @(posedge clock) begin
         if (stg_en[SQ_BASE+3*k+1]) begin
            mid1_ff <= MID_W'(ah0_ff * al0_ff);
            ll1_ff  <= ll0_ff;
            hh1_ff  <= hh0_ff;
            neg1_ff <= neg0_ff;
         end
      end

      // The cross product appears twice, hence the shift by 33.
      assign sum = {hh1_ff, 64'd0}
                 + SUM_W'({mid1_ff, 33'd0})
                 + SUM_W'(ll1_ff)
                 + SUM_W'(HALF_Q28);

      always_ff @(posedge clock) begin
         if (stg_en[SQ_BASE+3*k+2]) begin
            sq_r_ff[k]   <= sum[SUM_W-1:FRAC_BITS];
            sq_neg_ff[k] <= neg1_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Divider setup: 1/p^16 in Q.30 is (2^58 + s/2) / s with s = p^16 in
   // Q.28. Above 2^59 the rounded reciprocal is zero, so the result
   // saturates to exactly one and the quotient is ignored.
   // ---------------------------------------------------------------------
   always_comb begin
      prep_in.num = ONE_Q58 + {1'b0, sq_r_ff[NUM_SQ-1][DEN_W-1:1]};
      prep_in.den = sq_r_ff[NUM_SQ-1][DEN_W-1:0];
      prep_in.neg = sq_neg_ff[NUM_SQ-1];
      prep_in.sat = sq_r_ff[NUM_SQ-1][SQR_W-1]
                  | (sq_r_ff[NUM_SQ-1][DEN_W-1] & (|sq_r_ff[NUM_SQ-1][DEN_W-2:0]));
   end

   always_ff @(posedge clock) begin
      if (stg_en[PREP]) begin
         prep_ff <= prep_in;
      end
   end

   erfpa_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v_ff[PREP]),
      .in_ready  (div_in_ready),
      .in_req    (prep_ff),
      .out_valid (div_out_valid),
      .out_ready (div_out_ready),
      .out_rsp   (div_rsp)
   );

   // ---------------------------------------------------------------------
   // Output register: magnitude 1 - 1/p^16, then the argument's sign.
   // ---------------------------------------------------------------------
   assign out_en        = !rsp_v_ff || rsp_tready;
   assign div_out_ready = out_en;

   assign mag_in      = div_rsp.sat ? ONE_Q30 : (ONE_Q30 - div_rsp.quo);
   assign rsp_data_in = div_rsp.neg ? (32'd0 - RES_W'(mag_in)) : RES_W'(mag_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (out_en) begin
         rsp_v_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;

   // With the output free, every stage can move, so a request is taken.
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_v_ff || rsp_tready) |-> req_tready)
      else $error("request refused although the output is free");

   // The divider never sees a divisor below one unless the result saturates.
   a_den_floor: assert property (@(posedge clock) disable iff (reset)
      (v_ff[PREP] && !prep_ff.sat) |-> (prep_ff.den >= DEN_W'(ONE_Q58 >> 30)))
      else $error("divisor below one");

   // Results stay within plus or minus one.
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> (($signed(rsp_data_ff) <= 32'sd1073741824)
                 && ($signed(rsp_data_ff) >= -32'sd1073741824)))
      else $error("result outside plus or minus one");

endmodule

`default_nettype wire

### src/erfpa_div.sv
// Pipelined restoring divider, one quotient bit per stage, with an elastic handshake.
`default_nettype none

module erfpa_div
   import erfpa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire div_req_type in_req,
   output logic             out_valid,
   input  wire logic        out_ready,
   output div_rsp_type      out_rsp
);

   localparam int NDIV = QUO_W;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] lo;
      logic [QUO_W-1:0] quo;
      logic [DEN_W-1:0] den;
      logic             neg;
      logic             sat;
   } dstage_type;

   dstage_type        st_ff [NDIV];
   dstage_type        st_in [NDIV];
   logic [NDIV-1:0]   v_ff;
   logic [NDIV-1:0]   v_in;
   logic [NDIV-1:0]   v_src;
   logic [NDIV-1:0]   en;

   // A stage can load when it is empty or when its item moves on.
   assign en[NDIV-1] = !v_ff[NDIV-1] || out_ready;
   for (genvar j = 0; j < NDIV - 1; j++) begin : g_en
      assign en[j] = !v_ff[j] || en[j+1];
   end

   assign v_src = {v_ff[NDIV-2:0], in_valid};
   assign v_in  = (en & v_src) | (~en & v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   for (genvar j = 0; j < NDIV; j++) begin : g_stage
      dstage_type        src;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              ge;

      if (j == 0) begin : g_first
         always_comb begin
            src.rem = DEN_W'(in_req.num[DEN_W-1:QUO_W]);
            src.lo  = in_req.num[QUO_W-1:0];
            src.quo = '0;
            src.den = in_req.den;
            src.neg = in_req.neg;
            src.sat = in_req.sat;
         end
      end else begin : g_next
         assign src = st_ff[j-1];
      end

      // Bring down the next dividend bit and try one subtraction.
      assign trial = {src.rem, src.lo[QUO_W-1]};
      assign diff  = trial - {1'b0, src.den};
      assign ge    = (trial >= {1'b0, src.den});

      always_comb begin
         st_in[j].rem = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         st_in[j].lo  = {src.lo[QUO_W-2:0], 1'b0};
         st_in[j].quo = {src.quo[QUO_W-2:0], ge};
         st_in[j].den = src.den;
         st_in[j].neg = src.neg;
         st_in[j].sat = src.sat;
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            st_ff[j] <= st_in[j];
         end
      end
   end

   assign in_ready    = en[0];
   assign out_valid   = v_ff[NDIV-1];
   assign out_rsp.quo = st_ff[NDIV-1].quo;
   assign out_rsp.neg = st_ff[NDIV-1].neg;
   assign out_rsp.sat = st_ff[NDIV-1].sat;

   // With the output free, the whole stage chain must be able to take a request.
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      out_ready |-> in_ready)
      else $error("divider input blocked although its output is free");

   // The partial remainder stays below the divisor after the first step.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (v_ff[0] && !st_ff[0].sat) |-> (st_ff[0].rem < st_ff[0].den))
      else $error("divider remainder not below divisor");

   // A reciprocal of a value of at least one never exceeds one.
   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_rsp.sat) |-> (out_rsp.quo <= ONE_Q30))
      else $error("reciprocal above one");

endmodule

`default_nettype wire
